FILE: src/tpbf_pkg.sv
package tpbf_pkg;

   // Default tree shape
   localparam int unsigned TreeLevelsDefault     = 5;
   localparam int unsigned SlotsPerBucketDefault = 4;

   // Field widths fixed by the item formats
   localparam int unsigned SlotIndexWidth = 7;
   localparam int unsigned NeedWidth      = 8;
   localparam int unsigned LeafWidth      = 5;
   localparam int unsigned ReqDataWidth   = 24;
   localparam int unsigned RspDataWidth   = 8;

   // Item modes
   localparam logic ModeWrite = 1'b0;
   localparam logic ModeQuery = 1'b1;

   // Per-level free counts travelling down the chain
   typedef struct packed {
      logic       valid;
      logic [3:0] free_cnt;
   } tpbf_level_type;

endpackage

FILE: src/tpbf_level_cell.sv
// One tree level: holds the occupancy bits of every bucket on that level,
// and counts the free slots of the bucket that the addressed path crosses.
module tpbf_level_cell #(
   parameter int unsigned LEVEL            = 0,
   parameter int unsigned SLOTS_PER_BUCKET = 4,
   parameter int unsigned BUCKET_BITS      = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    wr_en,
   input  logic [BUCKET_BITS-1:0]                  wr_bucket,
   input  logic [((SLOTS_PER_BUCKET>1)?$clog2(SLOTS_PER_BUCKET):1)-1:0] wr_slot,
   input  logic                                    wr_value,
   input  logic [BUCKET_BITS-1:0]                  rd_bucket,
   input  logic                                    rd_valid,
   output tpbf_pkg::tpbf_level_type                rd_out
);
   import tpbf_pkg::*;

   localparam int unsigned NumBuckets = 1 << LEVEL;
   localparam int unsigned LocalBits  = (LEVEL > 0) ? LEVEL : 1;

   logic [SLOTS_PER_BUCKET-1:0] full_ff [NumBuckets];
   logic [LocalBits-1:0]        local_wr;
   logic [LocalBits-1:0]        local_rd;
   logic [3:0]                  cnt;
   tpbf_level_type              out_ff;
   tpbf_level_type              out_in;

   assign local_wr = LocalBits'(wr_bucket);
   assign local_rd = LocalBits'(rd_bucket);

   // Occupancy store, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NumBuckets; b++) full_ff[b] <= '0;
      end else if (wr_en) begin
         full_ff[local_wr][wr_slot] <= wr_value;
      end
   end

   // Free count of the addressed bucket
   always_comb begin
      cnt = '0;
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
         cnt = cnt + {3'b000, ~full_ff[local_rd][s]};
      end
      out_in.valid    = rd_valid;
      out_in.free_cnt = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff <= '0;
      else       out_ff <= out_in;
   end

   assign rd_out = out_ff;
endmodule

FILE: src/tpbf_chain.sv
// Row of level cells plus an accumulating pipeline: level k's count is
// added at stage k, so one leaf's path total leaves the chain each cycle.
module tpbf_chain #(
   parameter int unsigned TREE_LEVELS      = 5,
   parameter int unsigned SLOTS_PER_BUCKET = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [TREE_LEVELS-1:0]        wr_bucket,
   input  logic                          scan_valid,
   input  logic [TREE_LEVELS-2:0]        scan_leaf,
   output logic                          sum_valid,
   output logic [TREE_LEVELS-2:0]        sum_leaf,
   output logic [11:0]                   sum_free,
   input  logic [((SLOTS_PER_BUCKET>1)?$clog2(SLOTS_PER_BUCKET):1)-1:0] wr_slot,
   input  logic                          wr_value
);
   import tpbf_pkg::*;

   localparam int unsigned LB = TREE_LEVELS - 1;

   // Per-level write decode: level of bucket b is floor(log2(b+1))
   logic [TREE_LEVELS-1:0] wr_lvl_en;
   logic [TREE_LEVELS-1:0] wr_off [TREE_LEVELS];
   logic [TREE_LEVELS:0]   bp1;

   assign bp1 = {1'b0, wr_bucket} + 1'b1;

   always_comb begin
      for (int k = 0; k < TREE_LEVELS; k++) begin
         wr_lvl_en[k] = wr_en && (bp1 >> k) == 1;
         wr_off[k]    = TREE_LEVELS'(bp1 - ((TREE_LEVELS+1)'(1) << k));
      end
   end

   // Delayed leaf index per stage and running sums
   logic [LB-1:0]  leaf_ff [TREE_LEVELS+1];
   logic           vld_ff  [TREE_LEVELS+1];
   logic [11:0]    acc_ff  [TREE_LEVELS+1];
   tpbf_level_type lvl_out [TREE_LEVELS];

   always_comb begin
      leaf_ff[0] = scan_leaf;
      vld_ff[0]  = scan_valid;
      acc_ff[0]  = '0;
   end

   for (genvar k = 0; k < TREE_LEVELS; k++) begin : g_level
      logic [TREE_LEVELS-1:0] rd_b;
      // Bucket on level k crossed by leaf path: top k bits of the leaf
      assign rd_b = TREE_LEVELS'(leaf_ff[k] >> (LB - k));

      tpbf_level_cell #(
         .LEVEL(k), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET), .BUCKET_BITS(TREE_LEVELS)
      ) u_cell (
         .clock(clock), .reset(reset),
         .wr_en(wr_lvl_en[k]), .wr_bucket(wr_off[k]),
         .wr_slot(wr_slot), .wr_value(wr_value),
         .rd_bucket(rd_b), .rd_valid(vld_ff[k]),
         .rd_out(lvl_out[k])
      );

      logic [LB-1:0] leaf_d_ff;
      logic [11:0]   acc_d_ff;
      always_ff @(posedge clock) begin
         leaf_d_ff <= leaf_ff[k];
         acc_d_ff  <= acc_ff[k];
      end
      always_comb begin
         leaf_ff[k+1] = leaf_d_ff;
         vld_ff[k+1]  = lvl_out[k].valid;
         acc_ff[k+1]  = acc_d_ff + 12'(lvl_out[k].free_cnt);
      end
   end

   assign sum_valid = vld_ff[TREE_LEVELS];
   assign sum_leaf  = leaf_ff[TREE_LEVELS];
   assign sum_free  = acc_ff[TREE_LEVELS];
endmodule

FILE: src/tree_path_best_fit_select_core.sv
// Best-fit leaf selector over a complete binary bucket tree. A write item
// (mode 0) updates one slot's occupancy and answers from the result register. A
// query item (mode 1) streams every leaf through a chain of one cell per tree
// level, one leaf per cycle; the chain is TREE_LEVELS deep. One item is in
// flight at a time; the input side stays closed until the result item has
// been taken.
module tree_path_best_fit_select_core #(
   parameter int unsigned TREE_LEVELS      = tpbf_pkg::TreeLevelsDefault,
   parameter int unsigned SLOTS_PER_BUCKET = tpbf_pkg::SlotsPerBucketDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] mode, [7:1] slot_index, [8] occupied, [16:9] needed_space (zero pad)
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] leaf_bucket, [5] is_larger
   output logic [7:0]  rsp_tdata
);
   import tpbf_pkg::*;

   localparam int unsigned LB        = TREE_LEVELS - 1;
   localparam int unsigned NumLeaves = 1 << LB;
   localparam int unsigned NumSlots  = ((1 << TREE_LEVELS) - 1) * SLOTS_PER_BUCKET;
   localparam int unsigned SB        = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int unsigned RecipShift = 12;
   localparam int unsigned RecipMul   =
      ((1 << RecipShift) + SLOTS_PER_BUCKET - 1) / SLOTS_PER_BUCKET;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_type;

   state_type       state_ff;
   logic [LB:0]     issue_ff;
   logic [NeedWidth-1:0] need_ff;
   logic            done_ff, larger_ff;
   logic [11:0]     gap_big_ff, gap_small_ff;
   logic [LB-1:0]   best_big_ff, best_small_ff;
   logic            rv_ff;
   logic [LeafWidth-1:0] rleaf_ff;
   logic            rlarger_ff;

   logic            acc;
   logic            mode;
   logic [SlotIndexWidth-1:0] sidx;
   logic [11:0]     bucket_full;
   logic [19:0]     quot_prod;
   logic            wr_en;

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign acc        = req_tvalid && req_tready;
   assign mode       = req_tdata[0];
   assign sidx       = req_tdata[7:1];

   // Slot split: the bucket comes from a reciprocal multiplication, which is
   // exact over the whole 7-bit index range; the slot is the remainder.
   logic [TREE_LEVELS-1:0] wr_bucket;
   logic [SB-1:0]          wr_slot;
   always_comb begin
      quot_prod   = 20'(sidx) * 20'(RecipMul);
      bucket_full = 12'(quot_prod[19:RecipShift]);
      wr_bucket   = TREE_LEVELS'(bucket_full);
      wr_slot     = SB'(12'(sidx) - bucket_full * 12'(SLOTS_PER_BUCKET));
   end
   assign wr_en = acc && mode == ModeWrite && 32'(sidx) < NumSlots;

   logic          sum_valid;
   logic [LB-1:0] sum_leaf;
   logic [11:0]   sum_free;

   tpbf_chain #(.TREE_LEVELS(TREE_LEVELS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_chain (
      .clock(clock), .reset(reset),
      .wr_en(wr_en), .wr_bucket(wr_bucket),
      .scan_valid(state_ff == ST_SCAN && !issue_ff[LB]),
      .scan_leaf(issue_ff[LB-1:0]),
      .sum_valid(sum_valid), .sum_leaf(sum_leaf), .sum_free(sum_free),
      .wr_slot(wr_slot), .wr_value(req_tdata[8])
   );

   logic [11:0] need_w;
   assign need_w = 12'(need_ff);

   // Sequencer, running best-fit choice and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         issue_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  if (mode == ModeWrite) begin
                     rv_ff      <= 1'b1;
                     rleaf_ff   <= '0;
                     rlarger_ff <= 1'b0;
                  end else begin
                     state_ff     <= ST_SCAN;
                     need_ff      <= req_tdata[16:9];
                     issue_ff     <= '0;
                     done_ff      <= 1'b0;
                     larger_ff    <= 1'b0;
                     gap_big_ff   <= '1;
                     gap_small_ff <= '1;
                     best_big_ff  <= '0;
                     best_small_ff <= '0;
                  end
               end
            end
            ST_SCAN, ST_DRAIN: begin
               if (state_ff == ST_SCAN) begin
                  if (issue_ff[LB]) state_ff <= ST_DRAIN;
                  else              issue_ff <= issue_ff + 1'b1;
               end
               if (sum_valid && !done_ff) begin
                  if (sum_free == need_w) begin
                     done_ff    <= 1'b1;
                     rleaf_ff   <= LeafWidth'(32'(sum_leaf) + NumLeaves - 1);
                     rlarger_ff <= larger_ff;
                  end else begin
                     if (sum_free > need_w) begin
                        larger_ff <= 1'b1;
                        if (sum_free - need_w < gap_big_ff) begin
                           gap_big_ff  <= sum_free - need_w;
                           best_big_ff <= sum_leaf;
                        end
                     end else if (!larger_ff && need_w - sum_free < gap_small_ff) begin
                        gap_small_ff  <= need_w - sum_free;
                        best_small_ff <= sum_leaf;
                     end
                  end
               end
               // Last leaf leaves the chain; an exact match on it was taken above
               if (state_ff == ST_DRAIN && sum_valid && 32'(sum_leaf) == NumLeaves - 1) begin
                  state_ff <= ST_IDLE;
                  rv_ff    <= 1'b1;
                  if (!done_ff && sum_free != need_w) begin
                     if (larger_ff || sum_free > need_w) begin
                        rlarger_ff <= 1'b1;
                        if (sum_free > need_w && sum_free - need_w < gap_big_ff)
                           rleaf_ff <= LeafWidth'(32'(sum_leaf) + NumLeaves - 1);
                        else
                           rleaf_ff <= LeafWidth'(32'(best_big_ff) + NumLeaves - 1);
                     end else begin
                        rlarger_ff <= 1'b0;
                        if (need_w - sum_free < gap_small_ff)
                           rleaf_ff <= LeafWidth'(32'(sum_leaf) + NumLeaves - 1);
                        else
                           rleaf_ff <= LeafWidth'(32'(best_small_ff) + NumLeaves - 1);
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {2'b00, rlarger_ff, rleaf_ff};
endmodule

FILE: src/tpbf_checker.sv
// Port-level checks for the best-fit selector.
module tpbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   // A held result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One item at a time: no new item while a result waits.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("item accepted while result pending");

   // A write item gives the zero result.
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[0] == tpbf_pkg::ModeWrite
      |=> rsp_tvalid && rsp_tdata == 8'h00)
      else $error("write result not zero");

   // Padding bits of the result stay zero.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] == 2'b00)
      else $error("result padding set");
endmodule

bind tree_path_best_fit_select_core tpbf_checker u_tpbf_checker (.*);

FILE: test/tree_path_best_fit_select_core_tb.sv
`timescale 1ns / 100ps

module tree_path_best_fit_select_core_tb;
   import tpbf_pkg::*;

   localparam int unsigned Levels    = TreeLevelsDefault;
   localparam int unsigned PerBucket = SlotsPerBucketDefault;
   localparam int unsigned NumBuckets = (1 << Levels) - 1;
   localparam int unsigned NumLeaves  = 1 << (Levels - 1);
   localparam int unsigned NumSlots   = NumBuckets * PerBucket;
   localparam int unsigned RandomItems = 1500;
   localparam int unsigned CycleLimit  = 400000;

   typedef struct packed {
      logic       mode;
      logic [6:0] slot_index;
      logic       occupied;
      logic [7:0] needed_space;
   } request_t;

   typedef struct packed {
      logic [4:0] leaf_bucket;
      logic       is_larger;
   } answer_t;

   // One directed row: the item, and an optional typed-in answer.
   typedef struct packed {
      request_t req;
      logic     fixed;
      answer_t  ans;
   } directed_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   bit          occupancy [NumSlots];
   answer_t     pending_answers [$];
   int unsigned failures = 0;
   int unsigned answers_seen = 0;
   int unsigned queries_sent = 0;
   int unsigned cycles = 0;
   bit          sending_done = 1'b0;
   bit          quiet_phase = 1'b0;

   tree_path_best_fit_select_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Free slots on the path from the root down to one leaf.
   function automatic int unsigned free_on_path(int unsigned leaf);
      int unsigned b;
      int unsigned count;
      b = leaf + NumLeaves - 1;
      count = 0;
      for (int lvl = 0; lvl < Levels; lvl++) begin
         for (int s = 0; s < PerBucket; s++) begin
            if (b * PerBucket + s < NumSlots && !occupancy[b * PerBucket + s]) count++;
         end
         b = (b == 0) ? 0 : (b - 1) / 2;
      end
      return count;
   endfunction

   // Applies one item to the occupancy copy and returns the expected answer.
   function automatic answer_t best_fit_answer(request_t r);
      answer_t a;
      int unsigned q, best_big, best_small, gap_big, gap_small;
      bit larger;
      a = '0;
      if (r.mode == ModeWrite) begin
         if (r.slot_index < NumSlots) occupancy[r.slot_index] = r.occupied;
         return a;
      end
      best_big = 0;
      best_small = 0;
      gap_big = '1;
      gap_small = '1;
      larger = 1'b0;
      for (int unsigned i = 0; i < NumLeaves; i++) begin
         q = free_on_path(i);
         if (q == r.needed_space) begin
            a.leaf_bucket = 5'(i + NumLeaves - 1);
            a.is_larger = larger;
            return a;
         end
         if (q > r.needed_space) begin
            larger = 1'b1;
            if (q - r.needed_space < gap_big) begin
               gap_big = q - r.needed_space;
               best_big = i;
            end
         end
         if (q < r.needed_space && !larger && r.needed_space - q < gap_small) begin
            gap_small = r.needed_space - q;
            best_small = i;
         end
      end
      a.leaf_bucket = 5'((larger ? best_big : best_small) + NumLeaves - 1);
      a.is_larger = larger;
      return a;
   endfunction

   // Offers one item, with an optional idle burst first, and waits for acceptance.
   task automatic send_item(request_t r, bit fixed, answer_t fixed_ans);
      answer_t predicted;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, r.needed_space, r.occupied, r.slot_index, r.mode};
      do @(posedge clock); while (!req_tready);
      predicted = best_fit_answer(r);
      if (fixed && predicted != fixed_ans) begin
         $error("directed row answer: expected %h, predicted %h", fixed_ans, predicted);
         failures++;
      end
      pending_answers.insert(pending_answers.size(), fixed ? fixed_ans : predicted);
      if (r.mode == ModeQuery) queries_sent++;
   endtask

   function automatic request_t random_item();
      request_t r;
      r.mode = 1'($urandom_range(0, 1));
      r.slot_index = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(NumSlots, 127))
                                                  : 7'($urandom_range(0, NumSlots - 1));
      r.occupied = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 3))
         0: r.needed_space = 8'($urandom);
         default: r.needed_space = 8'($urandom_range(0, Levels * PerBucket + 1));
      endcase
      return r;
   endfunction

   // Stimulus: directed table, then random items.
   initial begin
      directed_row_t rows [$];
      request_t r;
      rows = '{
         '{'{ModeQuery, 7'd0, 1'b0, 8'd20}, 1'b1, '{5'd15, 1'b0}},
         '{'{ModeQuery, 7'd127, 1'b1, 8'd0}, 1'b1, '{5'd15, 1'b1}},
         '{'{ModeQuery, 7'd0, 1'b0, 8'd255}, 1'b1, '{5'd15, 1'b0}},
         '{'{ModeWrite, 7'd0, 1'b1, 8'd0}, 1'b1, '{5'd0, 1'b0}},
         '{'{ModeWrite, 7'd123, 1'b1, 8'd255}, 1'b1, '{5'd0, 1'b0}},
         '{'{ModeWrite, 7'd124, 1'b1, 8'd0}, 1'b1, '{5'd0, 1'b0}},
         '{'{ModeWrite, 7'd127, 1'b1, 8'd255}, 1'b1, '{5'd0, 1'b0}},
         '{'{ModeQuery, 7'd0, 1'b0, 8'd19}, 1'b0, '0},
         '{'{ModeQuery, 7'd85, 1'b1, 8'd20}, 1'b0, '0},
         '{'{ModeWrite, 7'd60, 1'b1, 8'd0}, 1'b0, '0},
         '{'{ModeWrite, 7'd61, 1'b1, 8'd0}, 1'b0, '0},
         '{'{ModeQuery, 7'd0, 1'b0, 8'd18}, 1'b0, '0},
         '{'{ModeQuery, 7'd0, 1'b0, 8'd17}, 1'b0, '0},
         '{'{ModeWrite, 7'd123, 1'b0, 8'd0}, 1'b0, '0},
         '{'{ModeWrite, 7'd0, 1'b0, 8'd0}, 1'b0, '0},
         '{'{ModeQuery, 7'd42, 1'b1, 8'd1}, 1'b0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_item(rows[i].req, rows[i].fixed, rows[i].ans);
      for (int n = 0; n < RandomItems; n++) begin
         quiet_phase = n > RandomItems - 150;
         // Fill runs push the tree towards full and empty extremes.
         r = random_item();
         if (n % 300 > 200 && n % 300 < 260) begin
            r.mode = ModeWrite;
            r.occupied = 1'((n / 300) % 2);
         end
         send_item(r, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver: random stalls, one long hold-off early on, none at the end.
   initial begin
      int unsigned stall;
      @(negedge reset);
      rsp_tready <= 1'b0;
      repeat (400) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Answer checking against the oldest expectation.
   always @(posedge clock) begin
      answer_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.leaf_bucket = rsp_tdata[4:0];
         got.is_larger = rsp_tdata[5];
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $error("answer with nothing expected: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_answers.pop_front();
            if (got.leaf_bucket !== want.leaf_bucket) begin
               $error("leaf_bucket: expected %0d, actual %0d", want.leaf_bucket,
                      got.leaf_bucket);
               failures++;
            end
            if (got.is_larger !== want.is_larger) begin
               $error("is_larger: expected %0d, actual %0d", want.is_larger, got.is_larger);
               failures++;
            end
         end
      end
   end

   // End of run and timeout.
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("tree_path_best_fit_select_core regression: fail");
            $finish;
         end
         if (sending_done && pending_answers.size() == 0) break;
      end
      repeat (60) @(posedge clock);
      $display("Covered %0d answers, %0d of them best-fit queries, with random stalls",
               answers_seen, queries_sent);
      if (failures == 0 && pending_answers.size() == 0) begin
         $display("tree_path_best_fit_select_core regression: pass");
      end else begin
         $display("tree_path_best_fit_select_core regression: fail");
      end
      $finish;
   end

endmodule
